>>> rtl/core/bfa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator package
// Shared widths, command and status codes, reset values and the search result
// type passed between the allocator and its first-zero finder.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int MAX_FRAME_COUNT_DEF = 131072;
  localparam int FRAME_BYTES_DEF     = 4096;
  localparam int LOW_MEMORY_KB       = 1024;

  localparam int WORD_BITS   = 32;
  localparam int BIT_IDX_W   = 5;

  localparam int KB_W        = 22;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int FREE_ADDR_W = 32;
  localparam int ADDR_W      = 29;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 18;

  localparam logic [KB_W-1:0]        UPPER_KB_RESET     = 22'd523264;
  localparam logic [CFG_DATA_W-1:0]  RESERVED_END_RESET = 32'd2097152;

  localparam logic [CFG_INDEX_W-1:0] REG_UPPER_KB     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RESERVED_END = 1'd1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_MEMORY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FREED     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 2'd3;

  typedef struct packed {
    logic                 found;
    logic [BIT_IDX_W-1:0] bit_idx;
  } zero_hit_t;

endpackage

>>> rtl/core/bfa_first_zero.sv
// ----------------------------------------------------------------------------
// First free bit finder
// Returns the lowest clear bit of one map word among the bits marked valid.
// ----------------------------------------------------------------------------
module bfa_first_zero (
  input  logic [bfa_pkg::WORD_BITS-1:0] word,
  input  logic [bfa_pkg::WORD_BITS-1:0] valid_mask,
  output bfa_pkg::zero_hit_t            hit
);
  import bfa_pkg::*;

  logic [WORD_BITS-1:0] free_bits;

  always_comb begin
    free_bits   = ~word & valid_mask;
    hit.found   = |free_bits;
    hit.bit_idx = '0;
    // Walking down leaves the lowest set bit as the final choice.
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit.bit_idx = BIT_IDX_W'(i);
      end
    end
  end

endmodule

>>> rtl/core/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// One usage bit per frame, held in 32-bit words of a synchronous map memory.
// Allocation is first fit; a free clears the bit of the frame addressed.
//
//   Channel   Signals                                    Handshake
//   command   start, cmd, free_address                   start & !busy
//   result    done, frame_address, status,               done, one cycle
//             free_count, total_count
//   config    cfg_write, cfg_index, cfg_data             cfg_write
//
// An allocate keeps busy high while the scan reads one map word a cycle through
// the single read port and acts on each word once its registered read returns.
// A free keeps busy high while it reads the word, then modifies and writes it back.
// After reset or any register write the map is rebuilt in the PREP, LIMIT and
// CLEAR states, CLEAR writing every map word in turn; busy is high throughout.
// The result beat comes in the first cycle after busy falls and cannot be held
// off; the next command may be taken in that same cycle.
// FRAME_BYTES must be a power of two.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator #(
  parameter int MAX_FRAME_COUNT = bfa_pkg::MAX_FRAME_COUNT_DEF,
  parameter int FRAME_BYTES     = bfa_pkg::FRAME_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cmd,
  input  logic [bfa_pkg::FREE_ADDR_W-1:0]  free_address,
  output logic                             done,
  output logic [bfa_pkg::ADDR_W-1:0]       frame_address,
  output logic [bfa_pkg::STATUS_W-1:0]     status,
  output logic [bfa_pkg::COUNT_W-1:0]      free_count,
  output logic [bfa_pkg::COUNT_W-1:0]      total_count,
  input  logic                             cfg_write,
  input  logic [bfa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bfa_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bfa_pkg::*;

  localparam int MAP_WORDS = (MAX_FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_RAW   = $clog2(MAX_FRAME_COUNT + 1);
  localparam int CNT_W     = (CNT_RAW > BIT_IDX_W) ? CNT_RAW : BIT_IDX_W + 1;
  localparam int OFFSET_W  = $clog2(FRAME_BYTES);
  localparam int WIDE_W    = 34;
  localparam int CW        = CNT_W + WIDX_W + BIT_IDX_W;
  localparam int FRAME_W   = WIDX_W + BIT_IDX_W;
  localparam int EXT_W     = FREE_ADDR_W + CW;
  localparam int SHIFT_W   = FRAME_W + OFFSET_W + ADDR_W;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_PREP     = 3'd1;
  localparam logic [2:0] ST_LIMIT    = 3'd2;
  localparam logic [2:0] ST_CLEAR    = 3'd3;
  localparam logic [2:0] ST_SCAN     = 3'd4;
  localparam logic [2:0] ST_FREE_RD  = 3'd5;
  localparam logic [2:0] ST_FREE_CHK = 3'd6;

  logic [2:0]            state;
  logic [KB_W-1:0]       upper_kb;
  logic [CFG_DATA_W-1:0] reserved_end;
  logic [CNT_W-1:0]      frame_total;
  logic [CNT_W-1:0]      reserved_frames;
  logic [CNT_W-1:0]      used_count;
  logic [WIDX_W-1:0]     scan_last;
  logic [WORD_BITS-1:0]  tail_mask;
  logic [WIDX_W-1:0]     clr_idx;
  logic [WIDX_W-1:0]     iss_idx;
  logic [WIDX_W-1:0]     eval_idx;
  logic                  eval_valid;
  logic [WIDX_W-1:0]     fr_word;
  logic [BIT_IDX_W-1:0]  fr_bit;
  logic                  fr_ok;

  logic [WORD_BITS-1:0]  usage_map [MAP_WORDS];
  logic [WORD_BITS-1:0]  rd_data;
  logic [WIDX_W-1:0]     mem_raddr;
  logic                  mem_we;
  logic [WIDX_W-1:0]     mem_waddr;
  logic [WORD_BITS-1:0]  mem_wdata;

  logic [WIDE_W-1:0]     total_raw;
  logic [WIDE_W-1:0]     res_raw;
  logic [CNT_W-1:0]      total_clamp;
  logic [CNT_W-1:0]      res_clamp;
  logic [CNT_W-1:0]      limit;
  logic [CW-1:0]         word_count;
  logic [CW-1:0]         clr_base;
  logic [WORD_BITS-1:0]  clr_word;
  logic [EXT_W-1:0]      fa_ext;

  logic [WORD_BITS-1:0]  scan_mask;
  zero_hit_t             hit;

  logic                  res_fire;
  logic [STATUS_W-1:0]   res_status;
  logic [FRAME_W-1:0]    res_frame;
  logic [CNT_W-1:0]      used_next;
  logic [CNT_W-1:0]      free_after;
  logic [CNT_W+COUNT_W-1:0] free_ext;
  logic [CNT_W+COUNT_W-1:0] total_ext;
  logic [SHIFT_W-1:0]    frame_ext;

  assign busy = (state != ST_IDLE);

  // Frame totals from the registers; the address shift is the division.
  always_comb begin
    total_raw = ((WIDE_W'(upper_kb) + WIDE_W'(LOW_MEMORY_KB)) << 10) >> OFFSET_W;
    res_raw   = (WIDE_W'(reserved_end) + WIDE_W'(FRAME_BYTES - 1)) >> OFFSET_W;
    total_clamp = (total_raw > WIDE_W'(MAX_FRAME_COUNT)) ? CNT_W'(MAX_FRAME_COUNT)
                                                         : total_raw[CNT_W-1:0];
    res_clamp   = (res_raw > WIDE_W'(MAX_FRAME_COUNT)) ? CNT_W'(MAX_FRAME_COUNT)
                                                       : res_raw[CNT_W-1:0];
    limit       = (reserved_frames < frame_total) ? reserved_frames : frame_total;
    word_count  = (CW'(frame_total) + CW'(WORD_BITS - 1)) >> BIT_IDX_W;
  end

  // Initial content of one map word during the rebuild pass.
  always_comb begin
    clr_base = CW'(clr_idx) << BIT_IDX_W;
    if (clr_base + CW'(WORD_BITS) <= CW'(reserved_frames)) begin
      clr_word = '1;
    end else if (clr_base >= CW'(reserved_frames)) begin
      clr_word = '0;
    end else begin
      clr_word = ~({WORD_BITS{1'b1}} << reserved_frames[BIT_IDX_W-1:0]);
    end
  end

  assign fa_ext    = EXT_W'(free_address) >> OFFSET_W;
  assign mem_raddr = (state == ST_FREE_RD) ? fr_word : iss_idx;
  assign scan_mask = (eval_idx == scan_last) ? tail_mask : '1;

  bfa_first_zero u_first_zero (
    .word       (rd_data),
    .valid_mask (scan_mask),
    .hit        (hit)
  );

  // Result and write-back decisions for the word that has just been read.
  always_comb begin
    res_fire   = 1'b0;
    res_status = STATUS_IGNORED;
    res_frame  = '0;
    used_next  = used_count;
    mem_we     = 1'b0;
    mem_waddr  = clr_idx;
    mem_wdata  = clr_word;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_SCAN: begin
        if (eval_valid) begin
          if (hit.found) begin
            res_fire   = 1'b1;
            res_status = STATUS_ALLOCATED;
            res_frame  = {eval_idx, hit.bit_idx};
            used_next  = used_count + CNT_W'(1);
            mem_we     = 1'b1;
            mem_waddr  = eval_idx;
            mem_wdata  = rd_data | (WORD_BITS'(1) << hit.bit_idx);
          end else if (eval_idx == scan_last) begin
            res_fire   = 1'b1;
            res_status = STATUS_NO_MEMORY;
          end
        end
      end
      ST_FREE_CHK: begin
        res_fire = 1'b1;
        if (fr_ok && rd_data[fr_bit]) begin
          res_status = STATUS_FREED;
          used_next  = used_count - CNT_W'(1);
          mem_we     = 1'b1;
          mem_waddr  = fr_word;
          mem_wdata  = rd_data & ~(WORD_BITS'(1) << fr_bit);
        end
      end
      default: begin
        res_fire = 1'b0;
      end
    endcase
    free_after = frame_total - used_next;
    free_ext   = (CNT_W + COUNT_W)'(free_after);
    total_ext  = (CNT_W + COUNT_W)'(frame_total);
    frame_ext  = SHIFT_W'(res_frame) << OFFSET_W;
  end

  // Map memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      usage_map[mem_waddr] <= mem_wdata;
    end
    rd_data <= usage_map[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_PREP;
      upper_kb     <= UPPER_KB_RESET;
      reserved_end <= RESERVED_END_RESET;
      eval_valid   <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= res_fire;
      if (res_fire) begin
        used_count    <= used_next;
        status        <= res_status;
        frame_address <= frame_ext[ADDR_W-1:0];
        free_count    <= free_ext[COUNT_W-1:0];
        total_count   <= total_ext[COUNT_W-1:0];
      end
      // A register write rebuilds the map from scratch.
      if (cfg_write) begin
        if (cfg_index == REG_UPPER_KB) begin
          upper_kb <= cfg_data[KB_W-1:0];
        end
        if (cfg_index == REG_RESERVED_END) begin
          reserved_end <= cfg_data;
        end
        eval_valid <= 1'b0;
        state      <= ST_PREP;
      end else begin
        case (state)
          ST_IDLE: begin
            if (start) begin
              iss_idx    <= '0;
              eval_valid <= 1'b0;
              fr_word    <= fa_ext[FRAME_W-1:BIT_IDX_W];
              fr_bit     <= fa_ext[BIT_IDX_W-1:0];
              fr_ok      <= (fa_ext < EXT_W'(frame_total));
              state      <= (cmd == CMD_ALLOC) ? ST_SCAN : ST_FREE_RD;
            end
          end
          ST_PREP: begin
            frame_total     <= total_clamp;
            reserved_frames <= res_clamp;
            state           <= ST_LIMIT;
          end
          ST_LIMIT: begin
            reserved_frames <= limit;
            used_count      <= limit;
            scan_last       <= WIDX_W'(word_count - CW'(1));
            tail_mask       <= (frame_total[BIT_IDX_W-1:0] == '0) ? '1
                               : ~({WORD_BITS{1'b1}} << frame_total[BIT_IDX_W-1:0]);
            clr_idx         <= '0;
            state           <= ST_CLEAR;
          end
          ST_CLEAR: begin
            if (clr_idx == WIDX_W'(MAP_WORDS - 1)) begin
              state <= ST_IDLE;
            end else begin
              clr_idx <= clr_idx + WIDX_W'(1);
            end
          end
          ST_SCAN: begin
            // Reads run one word ahead of the check and park on the last word.
            eval_valid <= !res_fire;
            eval_idx   <= iss_idx;
            if (iss_idx != scan_last) begin
              iss_idx <= iss_idx + WIDX_W'(1);
            end
            if (res_fire) begin
              state <= ST_IDLE;
            end
          end
          ST_FREE_RD: begin
            state <= ST_FREE_CHK;
          end
          ST_FREE_CHK: begin
            state <= ST_IDLE;
          end
          default: begin
            state <= ST_PREP;
          end
        endcase
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat given while the allocator is still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (used_count <= frame_total))
    else $error("used frame count exceeds the frame total");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && eval_valid) |-> (eval_idx <= scan_last))
    else $error("scan checked a word beyond the last managed word");

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator testbench
// Drives allocate and free commands through the start/busy port and checks
// every result beat against a first-fit usage map kept here. Several memory
// sizes and reserved regions are programmed in turn, from the smallest map to
// the saturated one, with random gaps between commands.
// ----------------------------------------------------------------------------
module tb;
  import bfa_pkg::*;

  localparam int MAP_WORDS   = MAX_FRAME_COUNT_DEF / WORD_BITS;
  localparam int FRAME_SHIFT = $clog2(FRAME_BYTES_DEF);

  typedef struct packed {
    logic                   op;
    logic [FREE_ADDR_W-1:0] addr;
  } frame_cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   frame_address;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_count;
    logic [COUNT_W-1:0]  total_count;
  } frame_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   cmd = CMD_ALLOC;
  logic [FREE_ADDR_W-1:0] free_address = '0;
  logic                   done;
  logic [ADDR_W-1:0]      frame_address;
  logic [STATUS_W-1:0]    status;
  logic [COUNT_W-1:0]     free_count;
  logic [COUNT_W-1:0]     total_count;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_UPPER_KB;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Mirror of the block's map and counters
  logic [WORD_BITS-1:0] frame_map [MAP_WORDS];
  int                   frames_total;
  int                   frames_used;
  logic [KB_W-1:0]       upper_kb_reg;
  logic [CFG_DATA_W-1:0] reserved_end_reg;

  frame_cmd_t    pending_cmds [$];
  frame_result_t expected_results [$];
  frame_cmd_t    next_cmd;

  int cmds_queued = 0;
  int results_seen = 0;
  int failures = 0;
  int config_writes = 0;
  int status_seen [4] = '{default: 0};
  int gap_left = 0;
  int calm_left = 0;
  bit cmd_accepted = 1'b0;

  bitmap_frame_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .free_address  (free_address),
    .done          (done),
    .frame_address (frame_address),
    .status        (status),
    .free_count    (free_count),
    .total_count   (total_count),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void rebuild_frame_map();
    longint unsigned frames;
    longint unsigned reserved;
    int              marked;
    frames = ((64'(LOW_MEMORY_KB) + 64'(upper_kb_reg)) * 64'd1024) / 64'(FRAME_BYTES_DEF);
    if (frames > 64'(MAX_FRAME_COUNT_DEF)) frames = 64'(MAX_FRAME_COUNT_DEF);
    frames_total = int'(frames);
    reserved = (64'(reserved_end_reg) + 64'(FRAME_BYTES_DEF) - 64'd1) / 64'(FRAME_BYTES_DEF);
    foreach (frame_map[w]) frame_map[w] = '0;
    marked = (reserved < frames) ? int'(reserved) : frames_total;
    for (int f = 0; f < marked; f++) frame_map[f / WORD_BITS][f % WORD_BITS] = 1'b1;
    frames_used = marked;
  endfunction

  function automatic frame_result_t predict_frame_op(input logic op,
                                                     input logic [FREE_ADDR_W-1:0] addr);
    frame_result_t res;
    int            f;
    bit            found;
    res = '0;
    if (op == CMD_ALLOC) begin
      f = 0;
      found = 1'b0;
      // Words beyond the total are never set, so a full word is always wholly in range.
      while (!found && f < frames_total) begin
        if (f % WORD_BITS == 0 && frame_map[f / WORD_BITS] == '1) begin
          f += WORD_BITS;
        end else if (!frame_map[f / WORD_BITS][f % WORD_BITS]) begin
          found = 1'b1;
        end else begin
          f++;
        end
      end
      if (found) begin
        frame_map[f / WORD_BITS][f % WORD_BITS] = 1'b1;
        frames_used++;
        res.frame_address = ADDR_W'(f * FRAME_BYTES_DEF);
        res.status = STATUS_ALLOCATED;
      end else begin
        res.status = STATUS_NO_MEMORY;
      end
    end else begin
      f = int'(addr >> FRAME_SHIFT);
      if (f < frames_total && frame_map[f / WORD_BITS][f % WORD_BITS]) begin
        frame_map[f / WORD_BITS][f % WORD_BITS] = 1'b0;
        frames_used--;
        res.status = STATUS_FREED;
      end else begin
        res.status = STATUS_IGNORED;
      end
    end
    res.free_count = COUNT_W'(frames_total - frames_used);
    res.total_count = COUNT_W'(frames_total);
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      calm_left = $urandom_range(8, 24);
      return 0;
    end
    if (roll < 45) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // Driver: a command stays on the port until the block takes it.
  always @(negedge clk) begin
    if (start && !cmd_accepted) begin
      // still waiting for the block to take this beat
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left--;
    end else if (pending_cmds.size() > 0) begin
      next_cmd = pending_cmds.pop_front();
      start <= 1'b1;
      cmd <= next_cmd.op;
      free_address <= next_cmd.addr;
      gap_left = pick_gap();
    end else begin
      start <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
      failures++;
    end
  endtask

  // Monitor: checks result beats, then predicts for a command taken at this edge.
  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t ns: result beat with nothing outstanding, actual addr 0x%h status %0d",
                 $time, frame_address, status);
        failures++;
      end else begin
        want = expected_results.pop_front();
        check_field("frame_address", 32'(want.frame_address), 32'(frame_address));
        check_field("status", 32'(want.status), 32'(status));
        check_field("free_count", 32'(want.free_count), 32'(free_count));
        check_field("total_count", 32'(want.total_count), 32'(total_count));
        status_seen[want.status]++;
      end
    end
    if (!rst && start && !busy) expected_results.push_back(predict_frame_op(cmd, free_address));
    cmd_accepted = !rst && start && !busy;
  end

  task automatic set_config(input logic [CFG_INDEX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] value);
    while (busy) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_UPPER_KB) upper_kb_reg = value[KB_W-1:0];
    else reserved_end_reg = value;
    rebuild_frame_map();
    config_writes++;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_op(input logic op, input logic [FREE_ADDR_W-1:0] addr);
    pending_cmds.push_back('{op: op, addr: addr});
    cmds_queued++;
  endtask

  task automatic drain();
    while (results_seen < cmds_queued) @(negedge clk);
  endtask

  function automatic logic [FREE_ADDR_W-1:0] pick_free_address();
    int roll;
    int frame;
    roll = $urandom_range(0, 99);
    if (roll < 30) return $urandom;
    // Bias towards the low frames, where the used ones sit on a large map.
    if (roll < 60) frame = $urandom_range(0, 700);
    else frame = $urandom_range(0, frames_total + 1);
    return FREE_ADDR_W'(frame) * FREE_ADDR_W'(FRAME_BYTES_DEF)
           + FREE_ADDR_W'($urandom_range(0, FRAME_BYTES_DEF - 1));
  endfunction

  task automatic queue_random_ops(input int count, input int alloc_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < alloc_pct) queue_op(CMD_ALLOC, FREE_ADDR_W'($urandom));
      else queue_op(CMD_FREE, pick_free_address());
    end
  endtask

  task automatic random_phase(input logic [KB_W-1:0] kb, input logic [CFG_DATA_W-1:0] res_end,
                              input int count, input int alloc_pct);
    drain();
    set_config(REG_UPPER_KB, CFG_DATA_W'(kb));
    set_config(REG_RESERVED_END, res_end);
    queue_random_ops(count, alloc_pct);
  endtask

  initial begin
    upper_kb_reg = UPPER_KB_RESET;
    reserved_end_reg = RESERVED_END_RESET;
    rebuild_frame_map();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset map: 131072 frames, the first 512 reserved.
    queue_op(CMD_ALLOC, '0);
    queue_op(CMD_ALLOC, '1);
    queue_op(CMD_FREE, 32'd513 * 32'd4096 + 32'hABC);
    queue_op(CMD_FREE, 32'd513 * 32'd4096);
    queue_op(CMD_ALLOC, '0);
    queue_op(CMD_FREE, '0);
    queue_op(CMD_ALLOC, '0);
    queue_op(CMD_FREE, '1);
    queue_op(CMD_FREE, 32'd131072 * 32'd4096);
    queue_op(CMD_FREE, 32'd131071 * 32'd4096 + 32'hFFF);

    // 281 frames, a partial last word, one frame left free after the reserved region.
    drain();
    set_config(REG_UPPER_KB, 32'd100);
    set_config(REG_RESERVED_END, 32'd280 * 32'd4096 - 32'd1);
    queue_op(CMD_ALLOC, '0);
    queue_op(CMD_ALLOC, '0);
    queue_op(CMD_FREE, 32'd280 * 32'd4096);
    queue_op(CMD_FREE, 32'd281 * 32'd4096);
    queue_op(CMD_ALLOC, '0);

    // Smallest map with nothing reserved, then with the reserved end at its top.
    drain();
    set_config(REG_UPPER_KB, 32'd0);
    set_config(REG_RESERVED_END, 32'd0);
    queue_op(CMD_ALLOC, '0);
    queue_op(CMD_FREE, 32'd0);
    drain();
    set_config(REG_RESERVED_END, 32'hFFFF_F000);
    queue_op(CMD_ALLOC, '0);
    queue_op(CMD_FREE, 32'd255 * 32'd4096);
    queue_op(CMD_ALLOC, '0);

    // Saturated map, wholly reserved: the scan runs over every word.
    drain();
    set_config(REG_UPPER_KB, 32'd4193279);
    queue_op(CMD_ALLOC, '0);
    queue_op(CMD_FREE, 32'd77777 * 32'd4096 + 32'd5);
    queue_op(CMD_ALLOC, '0);
    drain();
    set_config(REG_RESERVED_END, 32'd1);
    queue_op(CMD_ALLOC, '0);

    random_phase(22'd100, $urandom_range(0, 300 * 4096), 40, 55);
    random_phase(KB_W'($urandom_range(0, 3000)), $urandom_range(0, 400 * 4096), 38, 50);
    random_phase(KB_W'($urandom_range(523264, 4193279)), $urandom_range(0, 1024 * 4096),
                 38, 60);

    drain();
    repeat (64) @(negedge clk);
    $display("Ran %0d commands over %0d register writes, map sizes from 256 to 131072 frames.",
             cmds_queued, config_writes);
    $display("Results: %0d allocated, %0d out of memory, %0d freed, %0d ignored.",
             status_seen[STATUS_ALLOCATED], status_seen[STATUS_NO_MEMORY],
             status_seen[STATUS_FREED], status_seen[STATUS_IGNORED]);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Timed out with %0d results outstanding.", expected_results.size());
    $display("tb failed");
    $finish;
  end

endmodule
